// ===== src/relative_path_validator_unit_defines.svh =====
// assertion macros shared by the path validator rtl
`ifndef RELATIVE_PATH_VALIDATOR_UNIT_DEFINES_SVH
`define RELATIVE_PATH_VALIDATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define RPV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpv assertion failed");
// next-cycle implication, checked outside reset
`define RPV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpv assertion failed");
`else
`define RPV_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RPV_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/rpv_pkg.sv =====
`timescale 1ns / 1ps

package rpv_pkg;

    localparam int PATH_BYTES_DEF = 128;
    localparam int LEN_W          = 7;
    localparam int LEN_MAX        = 127;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_COLON = 8'h3a;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_START = 3'd1,
        ST_BAD_CHAR  = 3'd2,
        ST_BAD_SEG   = 3'd3,
        ST_BAD_END   = 3'd4
    } t_status;

    typedef struct packed {
        logic is_nul;
        logic is_slash;
        logic is_dot;
        logic allowed;
    } t_char_class;

endpackage

// ===== src/relative_path_validator_unit.sv =====
`timescale 1ns / 1ps
`include "relative_path_validator_unit_defines.svh"

// relative path validator: takes one path byte per beat on i_ch, a zero byte
// ends the path; one result beat (o_status, o_byte_count) comes out for each
// path, at the terminator or at byte PATH_BYTES when no terminator came in time.
// a byte is taken every cycle while the output side keeps up; the last byte of a
// path is captured in the input register, and its result then goes from the check
// logic into the output register, raising o_valid, once that output register is
// free to take it (a stalled result held there delays it). o_stall rises only when the input
// register holds a byte and the output register holds a result that is being
// stalled. status codes: 0 ok, 1 bad start or empty path, 2 bad character,
// 3 empty or ".." inner segment, 4 too long or bad last segment; o_byte_count
// is the byte count (capped at 127) for an ok path and zero otherwise

module relative_path_validator_unit #(
    parameter int PATH_BYTES = rpv_pkg::PATH_BYTES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // byte input channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [7:0]                i_ch,
    // result channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [2:0]                o_status,
    output logic [rpv_pkg::LEN_W-1:0] o_byte_count
);

    // input register
    logic                      r_in_valid, n_in_valid;
    logic [7:0]                r_in_ch;

    // output register
    logic                      r_out_valid, n_out_valid;
    rpv_pkg::t_status          r_out_status;
    logic [rpv_pkg::LEN_W-1:0] r_out_len;

    logic                      in_accept;
    logic                      out_free;   // output register can take a new result
    logic                      fire;       // the buffered byte is processed this cycle

    rpv_pkg::t_char_class      ch_class;
    logic                      res_valid;
    rpv_pkg::t_status          res_status;
    logic [rpv_pkg::LEN_W-1:0] res_len;

    // handshake and flow control
    always_comb begin
        out_free  = !r_out_valid || !i_stall;
        fire      = r_in_valid && out_free;
        o_stall   = r_in_valid && !out_free;
        in_accept = i_valid && !o_stall;
    end

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (fire && res_valid) begin
            n_out_valid = 1'b1;
        end else if (out_free) begin
            // current result handed off (or none was held)
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_ch <= i_ch;
        end
        if (fire && res_valid) begin
            r_out_status <= res_status;
            r_out_len    <= res_len;
        end
    end

    // byte classification
    rpv_char_class u_char_class (
        .i_ch    (r_in_ch),
        .o_class (ch_class)
    );

    // per-path state and result decision
    rpv_path_check #(
        .PATH_BYTES (PATH_BYTES)
    ) u_path_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_class       (ch_class),
        .o_res_valid   (res_valid),
        .o_status      (res_status),
        .o_byte_count  (res_len)
    );

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_byte_count  = r_out_len;

    `RPV_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_stall,
        r_in_valid && r_out_valid && i_stall)
    `RPV_ASSERT_IMP(a_len_zero_on_error, i_clk, i_rst_n,
        o_valid && (r_out_status != rpv_pkg::ST_OK), o_byte_count == '0)
    `RPV_ASSERT_IMP(a_ok_path_nonempty, i_clk, i_rst_n,
        o_valid && (r_out_status == rpv_pkg::ST_OK), o_byte_count != '0)
    `RPV_ASSERT_NXT(a_result_from_fire, i_clk, i_rst_n, !o_valid && !fire, !o_valid)

endmodule

// ===== src/rpv_char_class.sv =====
`timescale 1ns / 1ps

module rpv_char_class (
    input  logic [7:0]          i_ch,
    output rpv_pkg::t_char_class o_class
);

    logic is_lower;
    logic is_upper;
    logic is_digit;
    logic is_punct;

    always_comb begin
        is_lower = (i_ch >= 8'h61) && (i_ch <= 8'h7a);
        is_upper = (i_ch >= 8'h41) && (i_ch <= 8'h5a);
        is_digit = (i_ch >= 8'h30) && (i_ch <= 8'h39);
        is_punct = (i_ch == rpv_pkg::CH_SLASH) || (i_ch == rpv_pkg::CH_DOT) ||
                   (i_ch == rpv_pkg::CH_UNDER) || (i_ch == rpv_pkg::CH_DASH);

        o_class.is_nul   = (i_ch == rpv_pkg::CH_NUL);
        o_class.is_slash = (i_ch == rpv_pkg::CH_SLASH);
        o_class.is_dot   = (i_ch == rpv_pkg::CH_DOT);
        o_class.allowed  = (i_ch >= rpv_pkg::CH_SPACE) && (i_ch != rpv_pkg::CH_COLON) &&
                           (is_lower || is_upper || is_digit || is_punct);
    end

endmodule

// ===== src/rpv_path_check.sv =====
`timescale 1ns / 1ps
`include "relative_path_validator_unit_defines.svh"

module rpv_path_check #(
    parameter int PATH_BYTES = rpv_pkg::PATH_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  rpv_pkg::t_char_class        i_class,
    output logic                        o_res_valid,
    output rpv_pkg::t_status            o_status,
    output logic [rpv_pkg::LEN_W-1:0]   o_byte_count
);

    localparam int PosW = $clog2(PATH_BYTES);

    logic [PosW-1:0]  r_pos, n_pos;
    logic [1:0]       r_seg_len, n_seg_len;   // saturates at 3: only 0 and 2 matter
    logic [1:0]       r_seg_dots, n_seg_dots;
    rpv_pkg::t_status r_err, n_err;

    logic             seg_bad;
    logic [PosW:0]    pos_inc;
    logic             at_limit;
    rpv_pkg::t_status err_byte;

    always_comb begin
        seg_bad  = (r_seg_len == 2'd0) || ((r_seg_len == 2'd2) && (r_seg_dots == 2'd2));
        pos_inc  = {1'b0, r_pos} + {{PosW{1'b0}}, 1'b1};
        at_limit = (pos_inc == (PosW+1)'(PATH_BYTES));

        // first error wins
        err_byte = r_err;
        if (r_err == rpv_pkg::ST_OK) begin
            priority if ((r_pos == '0) && (i_class.is_slash || i_class.is_dot)) begin
                err_byte = rpv_pkg::ST_BAD_START;
            end else if (!i_class.allowed) begin
                err_byte = rpv_pkg::ST_BAD_CHAR;
            end else if (i_class.is_slash && seg_bad) begin
                err_byte = rpv_pkg::ST_BAD_SEG;
            end
        end
    end

    always_comb begin
        n_pos         = r_pos;
        n_seg_len     = r_seg_len;
        n_seg_dots    = r_seg_dots;
        n_err         = r_err;
        o_res_valid   = 1'b0;
        o_status      = rpv_pkg::ST_OK;
        o_byte_count  = '0;
        if (i_fire) begin
            if (i_class.is_nul) begin
                o_res_valid = 1'b1;
                priority if (r_pos == '0) begin
                    o_status = rpv_pkg::ST_BAD_START;
                end else if (r_err != rpv_pkg::ST_OK) begin
                    o_status = r_err;
                end else if (seg_bad) begin
                    o_status = rpv_pkg::ST_BAD_END;
                end else begin
                    o_status = rpv_pkg::ST_OK;
                end
                if (o_status == rpv_pkg::ST_OK) begin
                    o_byte_count = (9'(r_pos) > 9'(rpv_pkg::LEN_MAX)) ?
                                   rpv_pkg::LEN_W'(rpv_pkg::LEN_MAX) :
                                   rpv_pkg::LEN_W'(r_pos);
                end
                n_pos      = '0;
                n_seg_len  = '0;
                n_seg_dots = '0;
                n_err      = rpv_pkg::ST_OK;
            end else if (at_limit) begin
                o_res_valid = 1'b1;
                o_status    = (err_byte != rpv_pkg::ST_OK) ? err_byte : rpv_pkg::ST_BAD_END;
                n_pos       = '0;
                n_seg_len   = '0;
                n_seg_dots  = '0;
                n_err       = rpv_pkg::ST_OK;
            end else begin
                n_pos = pos_inc[PosW-1:0];
                n_err = err_byte;
                if (i_class.is_slash) begin
                    n_seg_len  = '0;
                    n_seg_dots = '0;
                end else begin
                    if (r_seg_len != 2'd3) begin
                        n_seg_len = r_seg_len + 2'd1;
                    end
                    if (i_class.is_dot && (r_seg_dots != 2'd3)) begin
                        n_seg_dots = r_seg_dots + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_seg_len  <= '0;
            r_seg_dots <= '0;
            r_err      <= rpv_pkg::ST_OK;
        end else begin
            r_pos      <= n_pos;
            r_seg_len  <= n_seg_len;
            r_seg_dots <= n_seg_dots;
            r_err      <= n_err;
        end
    end

    `RPV_ASSERT_NXT(a_clear_after_result, i_clk, i_rst_n, o_res_valid,
        (r_pos == '0) && (r_err == rpv_pkg::ST_OK))
    `RPV_ASSERT_IMP(a_pos_in_range, i_clk, i_rst_n, 1'b1,
        ({1'b0, r_pos} < (PosW+1)'(PATH_BYTES)))
    `RPV_ASSERT_IMP(a_fresh_path_clean, i_clk, i_rst_n, r_pos == '0,
        (r_err == rpv_pkg::ST_OK) && (r_seg_len == 2'd0) && (r_seg_dots == 2'd0))

endmodule

// ===== test/relative_path_validator_unit_tb.sv =====
`timescale 1ns / 1ps

module relative_path_validator_unit_tb;

    localparam int PATH_BYTES  = rpv_pkg::PATH_BYTES_DEF;
    localparam int ITEMS       = 1000;
    // directed bytes and the hold-off phase take up most of the rest
    localparam int PHASE_BYTES = ITEMS * 3 / 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 10;

    // per-path checker: follows the byte stream and keeps the expected results
    class path_scoreboard;
        int                        byte_pos;
        int                        seg_len;
        int                        seg_dots;
        rpv_pkg::t_status          first_err;
        rpv_pkg::t_status          status_q[$];
        logic [rpv_pkg::LEN_W-1:0] length_q[$];
        int                        mismatches;
        int                        results;
        int                        per_status[5];

        function new();
            clear_path();
            mismatches = 0;
            results = 0;
            foreach (per_status[i]) per_status[i] = 0;
        endfunction

        function void clear_path();
            byte_pos = 0;
            seg_len = 0;
            seg_dots = 0;
            first_err = rpv_pkg::ST_OK;
        endfunction

        static function bit char_ok(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
                   (c >= "0" && c <= "9") || c == rpv_pkg::CH_SLASH ||
                   c == rpv_pkg::CH_DOT || c == rpv_pkg::CH_UNDER ||
                   c == rpv_pkg::CH_DASH;
        endfunction

        function bit seg_bad();
            return seg_len == 0 || (seg_len == 2 && seg_dots == 2);
        endfunction

        function void latch_err(rpv_pkg::t_status code);
            if (first_err == rpv_pkg::ST_OK) first_err = code;
        endfunction

        function void push_result(rpv_pkg::t_status st, int len);
            status_q.push_back(st);
            length_q.push_back(rpv_pkg::LEN_W'(len));
            per_status[st]++;
        endfunction

        // one accepted byte in, zero or one expected result out
        function void note_byte(logic [7:0] c);
            rpv_pkg::t_status st;
            if (c == rpv_pkg::CH_NUL) begin
                st = first_err;
                if (byte_pos == 0) st = rpv_pkg::ST_BAD_START;
                else if (st == rpv_pkg::ST_OK && seg_bad()) st = rpv_pkg::ST_BAD_END;
                push_result(st, (st == rpv_pkg::ST_OK) ?
                            ((byte_pos > rpv_pkg::LEN_MAX) ? rpv_pkg::LEN_MAX : byte_pos) : 0);
                clear_path();
                return;
            end
            if (byte_pos == 0 && (c == rpv_pkg::CH_SLASH || c == rpv_pkg::CH_DOT))
                latch_err(rpv_pkg::ST_BAD_START);
            if (!char_ok(c)) latch_err(rpv_pkg::ST_BAD_CHAR);
            if (c == rpv_pkg::CH_SLASH) begin
                if (seg_bad()) latch_err(rpv_pkg::ST_BAD_SEG);
                seg_len = 0;
                seg_dots = 0;
            end else begin
                if (seg_len < 255) seg_len++;
                if (c == rpv_pkg::CH_DOT && seg_dots < 3) seg_dots++;
            end
            byte_pos++;
            if (byte_pos >= PATH_BYTES) begin
                // limit hit without a terminator
                push_result((first_err != rpv_pkg::ST_OK) ? first_err : rpv_pkg::ST_BAD_END, 0);
                clear_path();
            end
        endfunction

        function void check_result(logic [2:0] st, logic [rpv_pkg::LEN_W-1:0] len);
            rpv_pkg::t_status          exp_st;
            logic [rpv_pkg::LEN_W-1:0] exp_len;
            results++;
            if (status_q.size() == 0) begin
                $error("result beat with nothing expected: status %0d byte_count %0d", st, len);
                mismatches++;
                return;
            end
            exp_st = status_q.pop_front();
            exp_len = length_q.pop_front();
            if (st !== exp_st) begin
                $error("status mismatch: expected %0d, actual %0d", exp_st, st);
                mismatches++;
            end
            if (len !== exp_len) begin
                $error("byte_count mismatch: expected %0d, actual %0d", exp_len, len);
                mismatches++;
            end
        endfunction

        function int pending();
            return status_q.size();
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic [7:0]                i_ch = 8'h00;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic [2:0]                o_status;
    logic [rpv_pkg::LEN_W-1:0] o_byte_count;

    path_scoreboard sb;
    int cycle_count = 0;
    int bytes_in = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    logic [7:0] path_q[$];

    relative_path_validator_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_ch          (i_ch),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_byte_count  (o_byte_count)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result side backpressure, with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // sample both channels on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycle_count++;
            if (i_valid && !o_stall) begin
                sb.note_byte(i_ch);
                bytes_in++;
            end
            if (o_valid && !i_stall) sb.check_result(o_status, o_byte_count);
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d results still due", cycle_count,
                         sb.pending());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // one input beat; called at a falling edge, returns at the falling edge after the byte is taken
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_ch <= b;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
        send_byte(rpv_pkg::CH_NUL);
    endtask

    function automatic logic [7:0] name_char(bit allow_dot);
        case ($urandom_range(allow_dot ? 8 : 7))
            0, 1, 2: return "a" + 8'($urandom_range(25));
            3, 4:    return "A" + 8'($urandom_range(25));
            5:       return "0" + 8'($urandom_range(9));
            6:       return rpv_pkg::CH_UNDER;
            7:       return rpv_pkg::CH_DASH;
            default: return rpv_pkg::CH_DOT;
        endcase
    endfunction

    function automatic logic [7:0] bad_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (path_scoreboard::char_ok(c));
        return c;
    endfunction

    // mostly well-formed paths with random content, the rest broken or noise
    task automatic make_path(ref logic [7:0] q[$]);
        int mode;
        int n;
        q.delete();
        mode = $urandom_range(99);
        if (mode < 3) begin
            // at the length limit: either just fits with a terminator or runs out
            n = $urandom_range(1) ? PATH_BYTES - 1 : PATH_BYTES;
            for (int i = 0; i < n; i++)
                q.push_back((i % 11 == 10) ? rpv_pkg::CH_SLASH : name_char(i % 11 != 0));
            if ($urandom_range(3) == 0) q[$urandom_range(n - 1)] = bad_char();
            if (n < PATH_BYTES) q.push_back(rpv_pkg::CH_NUL);
            return;
        end
        n = $urandom_range(1, 4);
        for (int s = 0; s < n; s++) begin
            if (s > 0) q.push_back(rpv_pkg::CH_SLASH);
            if (s > 0 && $urandom_range(9) == 0) begin
                // lone or triple dot segments are legal
                repeat ($urandom_range(1) ? 3 : 1) q.push_back(rpv_pkg::CH_DOT);
            end else begin
                int seg_n;
                seg_n = $urandom_range(1, 6);
                for (int j = 0; j < seg_n; j++) q.push_back(name_char(!(s == 0 && j == 0)));
            end
        end
        if (mode == 69) q.delete();
        if (mode >= 70) begin
            case (mode % 8)
                0: q.insert($urandom_range(q.size()), bad_char());
                1: q.push_front(rpv_pkg::CH_SLASH);
                2: q.push_front(rpv_pkg::CH_DOT);
                3: begin
                    // empty inner segment
                    q.push_back(rpv_pkg::CH_SLASH);
                    q.push_back(rpv_pkg::CH_SLASH);
                    q.push_back("b");
                end
                4: q.push_back(rpv_pkg::CH_SLASH);
                5: begin
                    // dot-dot inner segment
                    q.push_back(rpv_pkg::CH_SLASH);
                    q.push_back(rpv_pkg::CH_DOT);
                    q.push_back(rpv_pkg::CH_DOT);
                    q.push_back(rpv_pkg::CH_SLASH);
                    q.push_back("x");
                end
                6: begin
                    q.push_back(rpv_pkg::CH_SLASH);
                    q.push_back(rpv_pkg::CH_DOT);
                    q.push_back(rpv_pkg::CH_DOT);
                end
                default: begin
                    q.delete();
                    repeat ($urandom_range(1, 10)) q.push_back(8'($urandom_range(255)));
                end
            endcase
        end
        q.push_back(rpv_pkg::CH_NUL);
    endtask

    task automatic run_random(input int nbytes);
        int sent;
        sent = 0;
        while (sent < nbytes) begin
            make_path(path_q);
            foreach (path_q[i]) send_byte(path_q[i]);
            sent += path_q.size();
        end
    endtask

    initial begin
        sb = new();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty, leading slash and dot, bad characters, bad segments
        send_text("");
        send_text("a");
        send_text("Zz09_-");
        send_text("/a");
        send_text(".a");
        send_text("/");
        send_text("..");
        send_text("a/b");
        send_text("a//b");
        send_text("a/");
        send_text("a/../b");
        send_text("a/..");
        send_text("a/./b/...");
        send_text("a:b");
        send_text("a b");
        send_text("/a:b//c");
        send_text("a:b//c");
        // high and control bytes
        send_byte("a");
        send_byte(8'h80);
        send_byte(8'hff);
        send_byte(8'h7f);
        send_byte(8'h01);
        send_byte(rpv_pkg::CH_NUL);
        // longest legal path, then one that never terminates
        repeat (PATH_BYTES - 1) send_byte("x");
        send_byte(rpv_pkg::CH_NUL);
        repeat (PATH_BYTES) send_byte("y");

        // random traffic under changing handshake pressure
        send_idle_pct = 0;  stall_pct = 0;  run_random(PHASE_BYTES);
        send_idle_pct = 55; stall_pct = 0;  run_random(PHASE_BYTES);
        send_idle_pct = 0;  stall_pct = 55; run_random(PHASE_BYTES);
        send_idle_pct = 14; stall_pct = 14; run_random(PHASE_BYTES);

        // long receiver hold-off while bytes keep coming, so the input backs up
        send_idle_pct = 0;
        stall_pct = 0;
        @(posedge i_clk);
        hold_request = 150;
        @(negedge i_clk);
        run_random(60);
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d bytes in, %0d results checked over %0d cycles", bytes_in, sb.results,
                 cycle_count);
        $display("ok %0d, bad start %0d, bad char %0d, bad segment %0d, bad end %0d",
                 sb.per_status[rpv_pkg::ST_OK], sb.per_status[rpv_pkg::ST_BAD_START],
                 sb.per_status[rpv_pkg::ST_BAD_CHAR], sb.per_status[rpv_pkg::ST_BAD_SEG],
                 sb.per_status[rpv_pkg::ST_BAD_END]);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
